@@ sv/rrfb_pkg.sv @@
package rrfb_pkg;

    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam int          HDR_LEN         = 6;

    localparam logic [3:0] STEP_IDLE  = 4'd0;
    localparam logic [3:0] STEP_FIRST = 4'd1;
    localparam logic [3:0] STEP_LAST  = 4'd8;

    typedef enum logic [2:0] {
        SRC_B0     = 3'd0,
        SRC_B1     = 3'd1,
        SRC_B2     = 3'd2,
        SRC_B3     = 3'd3,
        SRC_B4     = 3'd4,
        SRC_B5     = 3'd5,
        SRC_CRC_LO = 3'd6,
        SRC_CRC_HI = 3'd7
    } t_src;

    typedef struct packed {
        logic       accept;
        logic       emit;
        t_src       src;
        logic       crc_upd;
        logic       last;
        logic [3:0] jmp_target;
        logic [3:0] idle_target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic emit;
        t_src src;
        logic crc_upd;
        logic last;
    } t_ctl;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_uword ucode(input logic [3:0] step);
        t_uword w;
        w = '{accept: 1'b1, emit: 1'b0, src: SRC_B0, crc_upd: 1'b0, last: 1'b0,
              jmp_target: STEP_FIRST, idle_target: STEP_IDLE};
        unique case (step)
            4'd0: begin
                w.accept = 1'b1;
            end
            4'd1: w = '{1'b0, 1'b1, SRC_B0, 1'b1, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd2: w = '{1'b0, 1'b1, SRC_B1, 1'b1, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd3: w = '{1'b0, 1'b1, SRC_B2, 1'b1, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd4: w = '{1'b0, 1'b1, SRC_B3, 1'b1, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd5: w = '{1'b0, 1'b1, SRC_B4, 1'b1, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd6: w = '{1'b0, 1'b1, SRC_B5, 1'b1, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd7: w = '{1'b0, 1'b1, SRC_CRC_LO, 1'b0, 1'b0, STEP_FIRST, STEP_IDLE};
            4'd8: w = '{1'b1, 1'b1, SRC_CRC_HI, 1'b0, 1'b1, STEP_FIRST, STEP_IDLE};
            default: begin
                w.accept = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/rrfb_seq.sv @@
module rrfb_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    input  logic [7:0]    i_reg_count,
    input  logic          i_out_free,
    output logic          o_ready,
    output rrfb_pkg::t_ctl o_ctl
);
    import rrfb_pkg::*;

    logic [3:0] r_step;
    logic [3:0] n_step;
    t_uword     w;
    logic       step_go;
    logic       start;

    assign w       = ucode(r_step);
    assign step_go = !w.emit || i_out_free;
    assign o_ready = w.accept && step_go;
    assign start   = i_valid && o_ready && !(!i_func && (i_reg_count == 8'h00));

    assign o_ctl.load    = start;
    assign o_ctl.emit    = w.emit && i_out_free;
    assign o_ctl.src     = w.src;
    assign o_ctl.crc_upd = w.crc_upd && w.emit && i_out_free;
    assign o_ctl.last    = w.last;

    always_comb begin
        if (!step_go) begin
            n_step = r_step;
        end else if (w.accept) begin
            n_step = start ? w.jmp_target : w.idle_target;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST)
        else $error("step counter out of program");

    a_start_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_step == STEP_FIRST)
        else $error("accepted request did not start the frame");

    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit && o_ctl.last) |=> (r_step == STEP_IDLE || r_step == STEP_FIRST))
        else $error("sequencer did not return after the last word");

    a_no_upd_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.crc_upd && o_ctl.load))
        else $error("CRC update collides with frame load");

endmodule

@@ sv/rrfb_datapath.sv @@
module rrfb_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrfb_pkg::t_ctl i_ctl,
    input  logic           i_func,
    input  logic [7:0]     i_slave_addr,
    input  logic [15:0]    i_reg_addr,
    input  logic [7:0]     i_reg_count,
    input  logic [15:0]    i_reg_value,
    input  logic           i_ready,
    output logic           o_out_free,
    output logic           o_valid,
    output logic [7:0]     o_frame_byte,
    output logic           o_last_byte
);
    import rrfb_pkg::*;

    logic [7:0]  r_store [HDR_LEN];
    logic [15:0] r_crc;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_valid;
    logic [7:0]  sel_byte;

    always_comb begin
        case (i_ctl.src)
            SRC_CRC_LO: sel_byte = r_crc[7:0];
            SRC_CRC_HI: sel_byte = r_crc[15:8];
            default:    sel_byte = r_store[3'(i_ctl.src)];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_store[0] <= i_slave_addr;
            r_store[1] <= i_func ? FC_WRITE_SINGLE : FC_READ_HOLDING;
            r_store[2] <= i_reg_addr[15:8];
            r_store[3] <= i_reg_addr[7:0];
            r_store[4] <= i_func ? i_reg_value[15:8] : 8'h00;
            r_store[5] <= i_func ? i_reg_value[7:0] : i_reg_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.load) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.crc_upd) begin
            r_crc <= crc_byte(r_crc, sel_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= i_ctl.last;
        end
    end

    assign o_out_free   = !r_out_valid || i_ready;
    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

endmodule

@@ sv/register_request_frame_builder.sv @@
// Builds one eight-word request frame per accepted request: slave address, function code,
// register address high and low, count or value high and low, then the CRC-16 of the
// first six bytes, low byte first, with o_last_byte set on the final word. Words leave
// one per cycle while the output is taken, and the next request is accepted in the cycle
// its predecessor's last word is loaded; from idle, acceptance moves the program to its
// first step, which loads the first word. A read with count zero is consumed without
// starting a frame and produces nothing. The nine-step control program has an idle step,
// then one step per word through the single output register; the first six feed the CRC.
module register_request_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_slave_addr,
    input  logic [15:0] i_reg_addr,
    input  logic [7:0]  i_reg_count,
    input  logic [15:0] i_reg_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);
    import rrfb_pkg::*;

    t_ctl ctl;
    logic out_free;

    rrfb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_reg_count (i_reg_count),
        .i_out_free  (out_free),
        .o_ready     (o_ready),
        .o_ctl       (ctl)
    );

    rrfb_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_func       (i_func),
        .i_slave_addr (i_slave_addr),
        .i_reg_addr   (i_reg_addr),
        .i_reg_count  (i_reg_count),
        .i_reg_value  (i_reg_value),
        .i_ready      (i_ready),
        .o_out_free   (out_free),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
